[hdl/wbps_pkg.sv]
package wbps_pkg;

	localparam int PATTERN_MAX = 16;
	localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
	localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int REG_BYTES   = 16;

	localparam int BYTE_W      = 8;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int MASK_W      = 16;
	localparam int PLEN_W      = 5;
	localparam int OCC_W       = 31;
	localparam int POS_W       = 32;
	localparam int STATUS_W    = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CARE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OCC      = 3'd4;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_FOUND     = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_INVALID   = 2'd2
	} status_t;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		byte_t [PATTERN_MAX-1:0] pat;
		logic  [PATTERN_MAX-1:0] care;
		logic  [LEN_W-1:0]       length;
		logic  [OCC_W-1:0]       occ;
	} cfg_t;

endpackage

[hdl/wbps_in_if.sv]
interface wbps_in_if
	import wbps_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] image_byte;
	logic              last_byte;

	modport source(output valid, image_byte, last_byte, input ready);
	modport sink(input valid, image_byte, last_byte, output ready);
endinterface

[hdl/wbps_out_if.sv]
interface wbps_out_if
	import wbps_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    match_offset;

	modport source(output valid, status, match_offset, input ready);
	modport sink(input valid, status, match_offset, output ready);
endinterface

[hdl/wbps_cfg_regs.sv]
module wbps_cfg_regs
	import wbps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] data,
	output cfg_t                  cfg
);

	logic [CFG_DATA_W-1:0] pat_low_q;
	logic [CFG_DATA_W-1:0] pat_high_q;
	logic [MASK_W-1:0]     care_q;
	logic [PLEN_W-1:0]     length_q;
	logic [OCC_W-1:0]      occ_q;
	logic [2*CFG_DATA_W-1:0] pat_all;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '0;
			length_q   <= '0;
			occ_q      <= '0;
		end else if (we) begin
			case (index)
				CFG_PAT_LOW:  pat_low_q  <= data;
				CFG_PAT_HIGH: pat_high_q <= data;
				CFG_CARE:     care_q     <= data[MASK_W-1:0];
				CFG_LENGTH:   length_q   <= data[PLEN_W-1:0];
				CFG_OCC:      occ_q      <= data[OCC_W-1:0];
				default: ;
			endcase
		end
	end

	assign pat_all = {pat_high_q, pat_low_q};

	// bytes beyond the register file are wildcards
	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pat
		if (j < REG_BYTES) begin : g_reg
			assign cfg.pat[j]  = pat_all[BYTE_W*j +: BYTE_W];
			assign cfg.care[j] = care_q[j];
		end else begin : g_none
			assign cfg.pat[j]  = '0;
			assign cfg.care[j] = 1'b0;
		end
	end

	assign cfg.length = (32'(length_q) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX) : LEN_W'(length_q);

	assign cfg.occ = occ_q;

endmodule

[hdl/wbps_window_match.sv]
module wbps_window_match
	import wbps_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  logic  clear,
	input  byte_t new_byte,
	input  cfg_t  cfg,
	output logic  hit
);

	byte_t window_q [PATTERN_MAX];
	byte_t new_win  [PATTERN_MAX];

	always_comb begin
		new_win[0] = new_byte;
		for (int k = 1; k < PATTERN_MAX; k++)
			new_win[k] = window_q[k-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PATTERN_MAX; k++)
				window_q[k] <= '0;
		end else if (step) begin
			for (int k = 0; k < PATTERN_MAX; k++)
				window_q[k] <= clear ? '0 : new_win[k];
		end
	end

	// window entry k lines up with pattern byte length-1-k
	always_comb begin
		logic [LEN_W-1:0] idx_full;
		logic [IDX_W-1:0] idx;
		hit = 1'b1;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			idx_full = cfg.length - LEN_W'(k) - LEN_W'(1);
			idx      = idx_full[IDX_W-1:0];
			if ((LEN_W'(k) < cfg.length) && cfg.care[idx] && (new_win[k] != cfg.pat[idx]))
				hit = 1'b0;
		end
	end

endmodule

[hdl/wildcard_byte_pattern_search_unit.sv]
// Wildcard byte pattern search. Image bytes stream in on the image channel, one item per
// byte, with last_byte set on the final byte. Exactly one result item leaves on the result
// channel for each image: status found (with the start offset of the wanted match), not
// found, or invalid when the pattern length register is zero. Throughput is one byte per
// clock unless a result stalls a last byte; the window compare and match counting run on
// the input register, whose last byte loads the output register. The output register lets
// the next image start while a result waits. The user must write configuration registers
// through cfg_we/cfg_index/cfg_data only while no image is in flight; it is not enforced.
module wildcard_byte_pattern_search_unit
	import wbps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	wbps_in_if.sink               image,
	wbps_out_if.source            result
);

	cfg_t  cfg;
	logic  v_s1;
	byte_t byte_s1;
	logic  last_s1;
	logic  advance;
	logic  step;
	logic  hit;
	logic  eligible;

	logic [POS_W-1:0] pos_q;
	logic [OCC_W-1:0] seen_q;
	logic             found_q;
	logic [POS_W-1:0] found_off_q;

	logic             out_valid_q;
	status_t          status_q;
	logic [POS_W-1:0] offset_q;

	logic             found_nx;
	logic [POS_W-1:0] found_off_nx;

	wbps_cfg_regs u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.index (cfg_index),
		.data  (cfg_data),
		.cfg   (cfg)
	);

	wbps_window_match u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.clear   (last_s1),
		.new_byte(byte_s1),
		.cfg     (cfg),
		.hit     (hit)
	);

	assign advance     = !last_s1 || !out_valid_q || result.ready;
	assign image.ready = !v_s1 || advance;
	assign step        = v_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (image.ready)
			v_s1 <= image.valid;
	end

	always_ff @(posedge clk) begin
		if (image.valid && image.ready) begin
			byte_s1 <= image.image_byte;
			last_s1 <= image.last_byte;
		end
	end

	assign eligible = (cfg.length != '0) && !found_q &&
		(({1'b0, pos_q} + 33'd1) >= 33'(cfg.length));

	always_comb begin
		found_nx     = found_q;
		found_off_nx = found_off_q;
		if (eligible && hit && (seen_q == cfg.occ)) begin
			found_nx     = 1'b1;
			found_off_nx = pos_q - (POS_W'(cfg.length) - POS_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			seen_q      <= '0;
			found_q     <= 1'b0;
			found_off_q <= '0;
		end else if (step) begin
			if (last_s1) begin
				pos_q       <= '0;
				seen_q      <= '0;
				found_q     <= 1'b0;
				found_off_q <= '0;
			end else begin
				pos_q       <= pos_q + POS_W'(1);
				found_q     <= found_nx;
				found_off_q <= found_off_nx;
				if (eligible && hit && (seen_q != cfg.occ) && (seen_q != '1))
					seen_q <= seen_q + OCC_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step && last_s1)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			if (cfg.length == '0) begin
				status_q <= STATUS_INVALID;
				offset_q <= '0;
			end else if (found_nx) begin
				status_q <= STATUS_FOUND;
				offset_q <= found_off_nx;
			end else begin
				status_q <= STATUS_NOT_FOUND;
				offset_q <= '0;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.status       = status_q;
	assign result.match_offset = offset_q;

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_s1 |=> (pos_q == '0) && !found_q && (seen_q == '0))
		else $error("scan state not cleared after last item");

	a_pos_inc: assert property (@(posedge clk) disable iff (!arst_n)
		step && !last_s1 |=> pos_q == $past(pos_q) + POS_W'(1))
		else $error("byte position did not advance");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!image.ready |-> v_s1 && last_s1 && out_valid_q && !result.ready)
		else $error("input stalled without a pending result");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_s1 |=> out_valid_q)
		else $error("last item produced no result");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import wbps_pkg::*;

	localparam int HOLD_CYCLES = 80;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES      = 12;

	typedef struct {
		byte_t data;
		logic  last;
	} image_item_t;

	typedef struct {
		status_t          status;
		logic [POS_W-1:0] offset;
	} search_result_t;

	bit clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wbps_in_if img_if();
	wbps_out_if res_if();

	wildcard_byte_pattern_search_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.image(img_if),
		.result(res_if)
	);

	// register copies
	byte_t pat_shadow [PATTERN_MAX];
	logic [MASK_W-1:0] care_shadow;
	logic [PLEN_W-1:0] len_shadow;
	logic [OCC_W-1:0] occ_shadow;

	// scan state of the search
	byte_t scan_window [PATTERN_MAX];
	logic [POS_W-1:0] scan_pos;
	logic [OCC_W-1:0] hits_before;
	logic hit_taken;
	logic [POS_W-1:0] hit_offset;

	image_item_t feed [$];
	search_result_t expected_results [$];
	image_item_t next_item;
	search_result_t want;

	bit in_taken;
	bit no_gaps;
	int src_gap;
	int sink_gap;
	int stall_left;
	int holds_asked;
	int holds_done;
	int quiet;
	int errors;
	int bytes_in;
	int n_found;
	int n_missing;
	int n_invalid;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 40)
			$display("%0t: mismatch: %s", $time, what);
	endtask

	task automatic clear_scan();
		foreach (scan_window[k])
			scan_window[k] = '0;
		scan_pos = '0;
		hits_before = '0;
		hit_taken = 1'b0;
		hit_offset = '0;
	endtask

	task automatic predict_byte(input byte_t b, input logic last);
		int len;
		bit hit;
		search_result_t r;
		len = (len_shadow > PATTERN_MAX) ? PATTERN_MAX : int'(len_shadow);
		for (int k = PATTERN_MAX - 1; k > 0; k--)
			scan_window[k] = scan_window[k - 1];
		scan_window[0] = b;
		if (len != 0 && !hit_taken && ({1'b0, scan_pos} + 33'd1 >= 33'(len))) begin
			hit = 1'b1;
			for (int j = 0; j < len; j++)
				if (care_shadow[j] && scan_window[len - 1 - j] != pat_shadow[j])
					hit = 1'b0;
			if (hit) begin
				if (hits_before == occ_shadow) begin
					hit_taken = 1'b1;
					hit_offset = scan_pos - POS_W'(len - 1);
				end else if (hits_before != '1) begin
					hits_before++;
				end
			end
		end
		if (!last) begin
			scan_pos++;
		end else begin
			if (len == 0) begin
				r.status = STATUS_INVALID;
				r.offset = '0;
			end else if (hit_taken) begin
				r.status = STATUS_FOUND;
				r.offset = hit_offset;
			end else begin
				r.status = STATUS_NOT_FOUND;
				r.offset = '0;
			end
			expected_results.push_back(r);
			clear_scan();
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_PAT_LOW: begin
				for (int j = 0; j < 8; j++)
					pat_shadow[j] = data[8*j +: 8];
			end
			CFG_PAT_HIGH: begin
				for (int j = 0; j < 8; j++)
					pat_shadow[8 + j] = data[8*j +: 8];
			end
			CFG_CARE: care_shadow = data[MASK_W-1:0];
			CFG_LENGTH: len_shadow = data[PLEN_W-1:0];
			CFG_OCC: occ_shadow = data[OCC_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
			input logic [MASK_W-1:0] care, input logic [PLEN_W-1:0] plen,
			input logic [OCC_W-1:0] occ);
		write_reg(CFG_PAT_LOW, lo);
		write_reg(CFG_PAT_HIGH, hi);
		write_reg(CFG_CARE, CFG_DATA_W'(care));
		write_reg(CFG_LENGTH, CFG_DATA_W'(plen));
		write_reg(CFG_OCC, CFG_DATA_W'(occ));
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (feed.size() != 0 || img_if.valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic push_image(input byte_t bytes [$]);
		foreach (bytes[i])
			feed.push_back(image_item_t'{data: bytes[i], last: (i == bytes.size() - 1)});
	endtask

	task automatic pick_settings(input int phase);
		logic [127:0] pat;
		logic [MASK_W-1:0] care;
		logic [PLEN_W-1:0] plen;
		logic [OCC_W-1:0] occ;
		pat = {$urandom, $urandom, $urandom, $urandom};
		if ($urandom_range(0, 2) == 0) begin
			for (int j = 0; j < 16; j++)
				case ($urandom_range(0, 2))
					0: pat[8*j +: 8] = 8'h00;
					1: pat[8*j +: 8] = 8'hff;
					default: pat[8*j +: 8] = 8'h5a;
				endcase
		end
		case ($urandom_range(0, 3))
			0: care = '0;
			1: care = '1;
			default: care = MASK_W'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0: plen = '0;
			1: plen = 5'd1;
			2: plen = 5'(PATTERN_MAX);
			3: plen = 5'($urandom_range(PATTERN_MAX + 1, 31));
			default: plen = 5'($urandom_range(2, 8));
		endcase
		if (phase == 0)
			plen = 5'(PATTERN_MAX);
		else if (phase == 3)
			plen = '0;
		occ = ($urandom_range(0, 7) == 0 || phase == 1) ? '1 : OCC_W'($urandom_range(0, 3));
		load_pattern(pat[63:0], pat[127:64], care, plen, occ);
		if (phase == 0)
			write_reg(CFG_OCC + 3'($urandom_range(1, 3)), {$urandom, $urandom});
	endtask

	task automatic queue_images(input int n_items, input int max_len);
		byte_t img [$];
		int len;
		int eff;
		int total;
		eff = (len_shadow > PATTERN_MAX) ? PATTERN_MAX : int'(len_shadow);
		total = 0;
		while (total < n_items) begin
			img.delete();
			if (max_len > 3 && $urandom_range(0, 11) == 0)
				len = $urandom_range(20, 80);
			else
				len = $urandom_range(1, max_len);
			while (img.size() < len) begin
				case ($urandom_range(0, 3))
					0: begin
						for (int j = 0; j < eff; j++)
							img.push_back(care_shadow[j] ? pat_shadow[j] : byte_t'($urandom));
						if (eff == 0)
							img.push_back(byte_t'($urandom));
					end
					1: img.push_back(byte_t'($urandom));
					default: img.push_back(pat_shadow[$urandom_range(0, PATTERN_MAX - 1)]);
				endcase
			end
			img = img[0:len-1];
			push_image(img);
			total += len;
		end
	endtask

	// image driver
	always @(negedge clk) begin
		if (!img_if.valid || in_taken) begin
			if (src_gap > 0) begin
				src_gap--;
				img_if.valid <= 1'b0;
			end else if (!no_gaps && feed.size() != 0 && $urandom_range(0, 9) == 0) begin
				src_gap = $urandom_range(0, 5);
				img_if.valid <= 1'b0;
			end else if (feed.size() != 0) begin
				next_item = feed.pop_front();
				img_if.valid <= 1'b1;
				img_if.image_byte <= next_item.data;
				img_if.last_byte <= next_item.last;
			end else begin
				img_if.valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_if.ready <= 1'b0;
		end else if (holds_done != holds_asked) begin
			holds_done++;
			stall_left = HOLD_CYCLES - 1;
			res_if.ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			res_if.ready <= 1'b0;
		end else if (!no_gaps && $urandom_range(0, 7) == 0) begin
			sink_gap = $urandom_range(0, 5);
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	// predict on accepted bytes, check accepted results
	always @(posedge clk) begin
		in_taken = img_if.valid && img_if.ready;
		if (arst_n) begin
			if (in_taken) begin
				bytes_in++;
				predict_byte(img_if.image_byte, img_if.last_byte);
			end
			if (res_if.valid && res_if.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result item with none expected");
				end else begin
					want = expected_results.pop_front();
					if (res_if.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							res_if.status, want.status));
					if (res_if.match_offset !== want.offset)
						report_mismatch($sformatf("match_offset %0d, expected %0d",
							res_if.match_offset, want.offset));
					case (want.status)
						STATUS_FOUND: n_found++;
						STATUS_NOT_FOUND: n_missing++;
						default: n_invalid++;
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((img_if.valid && img_if.ready) || (res_if.valid && res_if.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", quiet);
				$display("[wildcard_byte_pattern_search_unit] ERROR");
				$finish;
			end
		end
	end

	initial begin
		byte_t img [$];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		img_if.valid = 1'b0;
		img_if.image_byte = '0;
		img_if.last_byte = 1'b0;
		res_if.ready = 1'b0;
		foreach (pat_shadow[j])
			pat_shadow[j] = '0;
		care_shadow = '0;
		len_shadow = '0;
		occ_shadow = '0;
		clear_scan();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// length zero straight out of reset
		img = '{8'h00, 8'hff};
		push_image(img);
		wait_idle();

		// two-byte pattern, second match wanted, then an image shorter than the pattern
		load_pattern(64'h4241, 64'h0, 16'h0003, 5'd2, 31'd1);
		img = '{8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42};
		push_image(img);
		img = '{8'h41};
		push_image(img);
		wait_idle();

		// oversized length clamps to a full window
		load_pattern('1, '1, '1, '1, '0);
		img.delete();
		repeat (PATTERN_MAX) img.push_back(8'hff);
		push_image(img);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			no_gaps = (p >= PHASES - 2);
			pick_settings(p);
			if (p == 5) begin
				queue_images(102, 3);
				holds_asked++;
			end else begin
				queue_images(102, 24);
			end
			wait_idle();
		end

		repeat (8) @(negedge clk);
		$display("%0d image bytes in, results: %0d found, %0d not found, %0d invalid",
			bytes_in, n_found, n_missing, n_invalid);
		if (errors == 0)
			$display("[wildcard_byte_pattern_search_unit] OK");
		else
			$display("[wildcard_byte_pattern_search_unit] ERROR");
		$finish;
	end

endmodule
